// ===== rtl/core/erma_pkg.sv =====
// Shared constants for the event rate moving-average meter.
// No dependencies; used by the top level for port widths and defaults.
package erma_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int LEN_W     = 7;
    localparam int LEN_MAX   = (1 << LEN_W) - 1;
    localparam int LEN_RESET = 8;

    localparam int FIELD_W  = 32;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 4 * FIELD_W;

endpackage

// ===== rtl/core/erma_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module erma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/erma_div.sv =====
// Restoring divider, one quotient bit per cycle, for window sum / length.
// No dependencies; instantiated once per channel by the top level.
module erma_div #(
    parameter int DW = 39,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;

    logic [VW:0]      w_trial;
    logic [VW:0]      w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DW);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/event_rate_moving_average.sv =====
// Two-channel event rate meter with a moving-average window held in RAM.
// Depends on erma_pkg, erma_ram and erma_div.
//
//  channel  | ports                               | payload
//  ---------+-------------------------------------+------------------------------
//  input    | i_s_tvalid  o_s_tready  i_s_tdata   | in/out events, tlast = tick
//           | i_s_tlast                           |
//  result   | o_m_tvalid  i_m_tready  o_m_tdata   | last counts, averages
//  config   | i_cfg_valid o_cfg_ready i_cfg_data  | window length
//
// An item without tick keeps the meter idle and ready for the next item. A tick
// item passes through the transfer, one sum update, one divider start, the
// bit-serial dividers and the load of the output register, which takes longer
// while a previous result still waits there.
// Reset needs no clearing pass: the window is tracked by a fill flag. A stalled
// result holds the next tick item at its output load, and no input or config is
// accepted while it is held; plain items before it are still accepted.
module event_rate_moving_average #(
    parameter int MAX_WINDOW  = erma_pkg::MAX_WINDOW_DEF,
    parameter int COUNT_WIDTH = erma_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [erma_pkg::S_DATA_W-1:0] i_s_tdata,   // in_event, out_event
    input  logic                          i_s_tlast,   // tick
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // last_count_in, last_count_out, average_in, average_out
    output logic [erma_pkg::M_DATA_W-1:0] o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [erma_pkg::LEN_W-1:0]    i_cfg_data
);

    import erma_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = (COUNT_WIDTH + LEN_W > 64) ? 64 : COUNT_WIDTH + LEN_W;
    localparam int CMP_W = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_WINDOW >= LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(MAX_WINDOW);
    localparam logic [LEN_W-1:0] LEN_RST =
        (MAX_WINDOW < LEN_RESET) ? LEN_W'(MAX_WINDOW) : LEN_W'(LEN_RESET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_GO,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                 r_state;
    logic [LEN_W-1:0]       r_len;
    logic [AW-1:0]          r_pos;
    logic                   r_full;
    logic [COUNT_WIDTH-1:0] r_cnt_in;
    logic [COUNT_WIDTH-1:0] r_cnt_out;
    logic [COUNT_WIDTH-1:0] r_last_in;
    logic [COUNT_WIDTH-1:0] r_last_out;
    logic [SUM_W-1:0]       r_sum_in;
    logic [SUM_W-1:0]       r_sum_out;
    logic                   r_m_valid;
    logic [M_DATA_W-1:0]    r_m_data;

    logic [COUNT_WIDTH-1:0]   n_cnt_in;
    logic [COUNT_WIDTH-1:0]   n_cnt_out;
    logic [SUM_W-1:0]         n_sum_in;
    logic [SUM_W-1:0]         n_sum_out;
    logic [LEN_W-1:0]         n_len;
    logic [CMP_W-1:0]         n_pos_inc;

    logic                     w_s_acc;
    logic                     w_cfg_acc;
    logic                     w_out_free;
    logic                     w_wrap;
    logic [2*COUNT_WIDTH-1:0] w_rdata;
    logic [COUNT_WIDTH-1:0]   w_old_in;
    logic [COUNT_WIDTH-1:0]   w_old_out;
    logic                     w_div_go;
    logic                     w_busy_in;
    logic                     w_busy_out;
    logic [SUM_W-1:0]         w_quo_in;
    logic [SUM_W-1:0]         w_quo_out;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_div_go    = (r_state == ST_GO);

    always_comb begin
        n_cnt_in  = r_cnt_in;
        n_cnt_out = r_cnt_out;
        if (i_s_tdata[0] && !(&r_cnt_in)) begin
            n_cnt_in = r_cnt_in + 1'b1;
        end
        if (i_s_tdata[1] && !(&r_cnt_out)) begin
            n_cnt_out = r_cnt_out + 1'b1;
        end
    end

    // entries not yet written since the last clear read as zero
    assign w_old_in  = r_full ? w_rdata[COUNT_WIDTH-1:0] : '0;
    assign w_old_out = r_full ? w_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
    assign n_sum_in  = r_sum_in - SUM_W'(w_old_in) + SUM_W'(r_last_in);
    assign n_sum_out = r_sum_out - SUM_W'(w_old_out) + SUM_W'(r_last_out);

    assign n_pos_inc = CMP_W'(r_pos) + 1'b1;
    assign w_wrap    = (n_pos_inc == CMP_W'(r_len));
    assign n_len     = (i_cfg_data > LEN_CAP) ? LEN_CAP : i_cfg_data;

    erma_ram #(
        .WIDTH(2 * COUNT_WIDTH),
        .DEPTH(MAX_WINDOW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_RD),
        .i_waddr(r_pos),
        .i_wdata({r_last_out, r_last_in}),
        .i_raddr(r_pos),
        .o_rdata(w_rdata)
    );

    erma_div #(
        .DW(SUM_W),
        .VW(LEN_W)
    ) u_div_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_go),
        .i_dividend(r_sum_in),
        .i_divisor (r_len),
        .o_busy    (w_busy_in),
        .o_quotient(w_quo_in)
    );

    erma_div #(
        .DW(SUM_W),
        .VW(LEN_W)
    ) u_div_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_go),
        .i_dividend(r_sum_out),
        .i_divisor (r_len),
        .o_busy    (w_busy_out),
        .o_quotient(w_quo_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= LEN_RST;
            r_pos     <= '0;
            r_full    <= 1'b0;
            r_cnt_in  <= '0;
            r_cnt_out <= '0;
            r_sum_in  <= '0;
            r_sum_out <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        if (i_s_tlast) begin
                            r_last_in  <= n_cnt_in;
                            r_last_out <= n_cnt_out;
                            r_cnt_in   <= '0;
                            r_cnt_out  <= '0;
                            r_state    <= ST_RD;
                        end else begin
                            r_cnt_in  <= n_cnt_in;
                            r_cnt_out <= n_cnt_out;
                        end
                    end
                    if (w_cfg_acc && i_cfg_data != '0 && n_len != r_len) begin
                        r_len     <= n_len;
                        r_pos     <= '0;
                        r_full    <= 1'b0;
                        r_sum_in  <= '0;
                        r_sum_out <= '0;
                    end
                end
                ST_RD: begin
                    r_sum_in  <= n_sum_in;
                    r_sum_out <= n_sum_out;
                    if (w_wrap) begin
                        r_pos  <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_pos <= n_pos_inc[AW-1:0];
                    end
                    r_state <= ST_GO;
                end
                ST_GO: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!w_busy_in && !w_busy_out) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_m_data  <= {FIELD_W'(w_quo_out), FIELD_W'(w_quo_in),
                                      FIELD_W'(r_last_out), FIELD_W'(r_last_in)};
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_pos) < CMP_W'(r_len))
        else $error("write position outside window");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0 && r_len <= LEN_CAP)
        else $error("window length out of range");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy_in == w_busy_out)
        else $error("channel dividers out of step");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && i_s_tlast) |=>
            (r_cnt_in == '0 && r_cnt_out == '0 && r_state == ST_RD))
        else $error("tick transfer did not close the interval");
`endif

endmodule
